// ===== design/acs_pkg.sv =====
// shared types, constants and helper functions for the adc scan block
// no dependencies
package acs_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int RING_DEPTH   = 2;
    localparam int MASK_W       = 12;
    localparam int CHAN_W       = 4;
    localparam int SAMPLE_W     = 12;
    localparam int PRESCALE_W   = 3;
    localparam int PTR_W        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CIDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int STORE_DEPTH  = NUM_CHANNELS * RING_DEPTH;
    localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_CONVERT = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_ABORTED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd1;

    typedef struct packed {
        logic [1:0]          func;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [CHAN_W-1:0]   target_channel;
        logic [SAMPLE_W-1:0] sample_out;
        logic [1:0]          divider_code;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              push;
        logic              pop;
    } t_ptr_upd;

    typedef struct packed {
        logic             in_range;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic             full;
        logic             empty;
    } t_ptr_stat;

    typedef struct packed {
        logic              found;
        logic [CHAN_W-1:0] idx;
    } t_pick;

    function automatic logic chan_ok(input logic [CHAN_W-1:0] chan);
        return {2'b00, chan} < 6'(NUM_CHANNELS);
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] inc;
        inc = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
        return (inc >= (PTR_W+1)'(RING_DEPTH)) ? '0 : inc[PTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_addr(input logic [CHAN_W-1:0] chan,
                                                    input logic [PTR_W-1:0] ptr);
        return ADDR_W'(chan) * ADDR_W'(RING_DEPTH) + ADDR_W'(ptr);
    endfunction

    // lowest enabled channel at or above from
    function automatic t_pick pick_channel(input logic [MASK_W-1:0] mask,
                                           input logic [CHAN_W:0] from);
        t_pick res;
        res = '0;
        for (int c = MASK_W - 1; c >= 0; c--) begin
            if (c < NUM_CHANNELS && (CHAN_W+1)'(c) >= from && mask[c]) begin
                res.found = 1'b1;
                res.idx   = CHAN_W'(c);
            end
        end
        return res;
    endfunction

endpackage

// ===== design/acs_sample_ram.sv =====
// sample store: one write port, one read port with registered read data
// depends on acs_pkg
module acs_sample_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [acs_pkg::ADDR_W-1:0]    i_waddr,
    input  logic [acs_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [acs_pkg::ADDR_W-1:0]    i_raddr,
    output logic [acs_pkg::SAMPLE_W-1:0]  o_rdata
);
    import acs_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/acs_ring_ptrs.sv =====
// head and tail pointers of the per-channel rings, with full and empty status
// depends on acs_pkg
module acs_ring_ptrs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [acs_pkg::CHAN_W-1:0]  i_look_chan,
    output logic [acs_pkg::PTR_W-1:0]   o_look_tail,
    input  acs_pkg::t_ptr_upd           i_upd,
    output acs_pkg::t_ptr_stat          o_stat
);
    import acs_pkg::*;

    logic [PTR_W-1:0]  r_head [NUM_CHANNELS];
    logic [PTR_W-1:0]  r_tail [NUM_CHANNELS];
    logic [CIDX_W-1:0] look_idx;
    logic [CIDX_W-1:0] upd_idx;
    logic              upd_ok;

    assign look_idx = CIDX_W'(i_look_chan);
    assign upd_idx  = CIDX_W'(i_upd.chan);
    assign upd_ok   = chan_ok(i_upd.chan);

    assign o_look_tail = chan_ok(i_look_chan) ? r_tail[look_idx] : '0;

    always_comb begin
        o_stat          = '0;
        o_stat.in_range = upd_ok;
        if (upd_ok) begin
            o_stat.head  = r_head[upd_idx];
            o_stat.tail  = r_tail[upd_idx];
            o_stat.full  = ring_next(r_head[upd_idx]) == r_tail[upd_idx];
            o_stat.empty = r_head[upd_idx] == r_tail[upd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
            end
        end else if (upd_ok) begin
            if (i_upd.push) begin
                r_head[upd_idx] <= ring_next(r_head[upd_idx]);
            end
            if (i_upd.pop) begin
                r_tail[upd_idx] <= ring_next(r_tail[upd_idx]);
            end
        end
    end

endmodule

// ===== design/adc_scan_with_channel_fifos.sv =====
// adc scan sequencer with one sample ring per channel: top level
// depends on acs_pkg, acs_sample_ram and acs_ring_ptrs
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries items:
// sample arrived, read channel, start scan, wait timed out. Every item gives
// exactly one result on the output channel (o_out_valid / i_out_stall,
// payload o_out_data): a read answer, a convert command or a done report.
// Registers are written through i_cfg_valid / o_cfg_ready with i_cfg_index
// (0 enabled channel mask, 1 clock prescale) and i_cfg_data; other indexes
// are ignored. The config port is always ready.
// Timing: an item is accepted and the sample memory is read in that cycle;
// the item then waits in registers and executes once the output register
// is free, loading the output register. The input stalls while an item
// waits or executes, so a new item is not taken before the last one has
// executed; this follows from the registered read data of the sample memory
// and the read-modify-write of the ring pointers.
// Reset clears ring pointers, scan state, mask (0) and prescale (7); sample
// memory content is not cleared and needs no clearing pass.
// When the receiver stalls, the result holds in the output register; one
// further item can be taken and waits unexecuted until the register frees.
module adc_scan_with_channel_fifos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  acs_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output acs_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [acs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import acs_pkg::*;

    logic [MASK_W-1:0]     r_mask;
    logic [PRESCALE_W-1:0] r_prescale;
    logic                  r_busy;
    logic [1:0]            r_func;
    logic [CHAN_W-1:0]     r_chan;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_scan;
    logic [CHAN_W-1:0]     r_cur;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  n_scan;
    logic [CHAN_W-1:0]     n_cur;
    t_out_item             n_out;

    logic                  accept;
    logic                  fire;
    logic                  out_free;
    logic [PTR_W-1:0]      look_tail;
    t_ptr_upd              upd;
    t_ptr_stat             stat;
    t_pick                 pick;
    logic [CHAN_W:0]       pick_from;
    logic                  ram_re;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [1:0]            sample_st;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_busy && out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // memory read issued in the transfer cycle
    assign ram_re    = accept && i_in_data.func == FUNC_READ && chan_ok(i_in_data.channel);
    assign ram_raddr = ring_addr(i_in_data.channel, look_tail);

    acs_sample_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    acs_ring_ptrs u_ptrs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_look_chan (i_in_data.channel),
        .o_look_tail (look_tail),
        .i_upd       (upd),
        .o_stat      (stat)
    );

    assign pick_from = (r_func == FUNC_START) ? '0 : ({1'b0, r_cur} + (CHAN_W+1)'(1));
    assign pick      = pick_channel(r_mask, pick_from);
    assign ram_waddr = ring_addr(r_cur, stat.head);

    always_comb begin
        n_scan             = r_scan;
        n_cur              = r_cur;
        n_out              = '0;
        n_out.divider_code = 2'(r_prescale >> 1);
        upd                = '0;
        upd.chan           = (r_func == FUNC_SAMPLE) ? r_cur : r_chan;
        ram_we             = 1'b0;
        sample_st          = ST_OK;
        case (r_func)
            FUNC_SAMPLE: begin
                if (stat.in_range && !stat.full) begin
                    upd.push = fire;
                    ram_we   = fire;
                end else begin
                    sample_st = ST_DROPPED;
                end
                n_out.status = sample_st;
                n_out.kind   = KIND_DONE;
                if (r_scan) begin
                    if (pick.found) begin
                        n_cur                = pick.idx;
                        n_out.kind           = KIND_CONVERT;
                        n_out.target_channel = pick.idx;
                    end else begin
                        n_scan = 1'b0;
                    end
                end
            end
            FUNC_READ: begin
                n_out.kind           = KIND_READ;
                n_out.target_channel = r_chan;
                if (stat.in_range && !stat.empty) begin
                    upd.pop          = fire;
                    n_out.sample_out = ram_rdata;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            FUNC_START: begin
                if (pick.found) begin
                    n_scan               = 1'b1;
                    n_cur                = pick.idx;
                    n_out.kind           = KIND_CONVERT;
                    n_out.target_channel = pick.idx;
                end else begin
                    n_scan     = 1'b0;
                    n_out.kind = KIND_DONE;
                end
            end
            default: begin
                n_out.kind = KIND_DONE;
                if (r_scan) begin
                    n_scan       = 1'b0;
                    n_out.status = ST_ABORTED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_prescale  <= '1;
            r_busy      <= 1'b0;
            r_scan      <= 1'b0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ENABLED:  r_mask     <= i_cfg_data[MASK_W-1:0];
                    CFG_PRESCALE: r_prescale <= i_cfg_data[PRESCALE_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_scan      <= n_scan;
                r_cur       <= n_cur;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_in_data.func;
            r_chan   <= i_in_data.channel;
            r_sample <= i_in_data.sample;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    a_convert_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_CONVERT
        |-> chan_ok(o_out_data.target_channel))
        else $error("convert command names a channel out of range");

    a_write_only_on_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_busy && r_func == FUNC_SAMPLE && stat.in_range && !stat.full))
        else $error("sample memory written without room in the ring");

    a_no_data_off_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_READ |-> o_out_data.sample_out == '0)
        else $error("sample data on a result that is not a read answer");

    a_scan_needs_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> chan_ok(r_cur))
        else $error("scan running on a channel out of range");

endmodule

// ===== dv/tb_adc_scan_with_channel_fifos.sv =====
// testbench for adc_scan_with_channel_fifos: directed and random item streams
// with random idling, checked against a behavioral predictor in a scoreboard
// depends on acs_pkg and the adc_scan_with_channel_fifos rtl
module tb_adc_scan_with_channel_fifos;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    class scan_scoreboard;
        t_out_item            expected_answers[$];
        int                   fail_count;
        logic [MASK_W-1:0]    chan_mask;
        logic [PRESCALE_W-1:0] prescale;
        logic [SAMPLE_W-1:0]  ring_data[NUM_CHANNELS][RING_DEPTH];
        int                   head[NUM_CHANNELS];
        int                   tail[NUM_CHANNELS];
        bit                   scanning;
        int                   cur_chan;

        function new();
            fail_count = 0;
            chan_mask  = '0;
            prescale   = 3'd7;
            scanning   = 1'b0;
            cur_chan   = 0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                head[c] = 0;
                tail[c] = 0;
                for (int s = 0; s < RING_DEPTH; s++) begin
                    ring_data[c][s] = '0;
                end
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENABLED: begin
                    chan_mask = data[MASK_W-1:0];
                end
                CFG_PRESCALE: begin
                    prescale = data[PRESCALE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // lowest enabled channel at or above from, NUM_CHANNELS if none
        function int first_enabled(int from);
            for (int c = from; c < NUM_CHANNELS; c++) begin
                if (chan_mask[c]) begin
                    return c;
                end
            end
            return NUM_CHANNELS;
        endfunction

        function void note_item(t_in_item it);
            t_out_item ans;
            int        nxt;
            int        rd;
            ans = '0;
            ans.divider_code = prescale[2:1];
            case (it.func)
                FUNC_SAMPLE: begin
                    ans.kind   = KIND_DONE;
                    ans.status = ST_DROPPED;
                    if (cur_chan < NUM_CHANNELS &&
                        (head[cur_chan] + 1) % RING_DEPTH != tail[cur_chan]) begin
                        ring_data[cur_chan][head[cur_chan]] = it.sample;
                        head[cur_chan] = (head[cur_chan] + 1) % RING_DEPTH;
                        ans.status = ST_OK;
                    end
                    if (scanning) begin
                        nxt = first_enabled(cur_chan + 1);
                        if (nxt < NUM_CHANNELS) begin
                            cur_chan = nxt;
                            ans.kind = KIND_CONVERT;
                            ans.target_channel = CHAN_W'(nxt);
                        end else begin
                            scanning = 1'b0;
                        end
                    end
                end
                FUNC_READ: begin
                    ans.kind           = KIND_READ;
                    ans.status         = ST_EMPTY;
                    ans.target_channel = it.channel;
                    rd = int'(it.channel);
                    if (rd < NUM_CHANNELS && head[rd] != tail[rd]) begin
                        ans.status     = ST_OK;
                        ans.sample_out = ring_data[rd][tail[rd]];
                        tail[rd] = (tail[rd] + 1) % RING_DEPTH;
                    end
                end
                FUNC_START: begin
                    nxt = first_enabled(0);
                    ans.status = ST_OK;
                    if (nxt < NUM_CHANNELS) begin
                        scanning = 1'b1;
                        cur_chan = nxt;
                        ans.kind = KIND_CONVERT;
                        ans.target_channel = CHAN_W'(nxt);
                    end else begin
                        scanning = 1'b0;
                        ans.kind = KIND_DONE;
                    end
                end
                default: begin
                    ans.kind   = KIND_DONE;
                    ans.status = scanning ? ST_ABORTED : ST_OK;
                    scanning   = 1'b0;
                end
            endcase
            expected_answers.push_back(ans);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            fail_count++;
        endfunction

        function void check_answer(t_out_item got);
            t_out_item want;
            if (expected_answers.size() == 0) begin
                $display("%0t: result expected none, actual %p", $time, got);
                fail_count++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.kind !== want.kind) report("kind", 16'(want.kind), 16'(got.kind));
            if (got.status !== want.status)
                report("status", 16'(want.status), 16'(got.status));
            if (got.target_channel !== want.target_channel)
                report("target_channel", 16'(want.target_channel),
                       16'(got.target_channel));
            if (got.sample_out !== want.sample_out)
                report("sample_out", 16'(want.sample_out), 16'(got.sample_out));
            if (got.divider_code !== want.divider_code)
                report("divider_code", 16'(want.divider_code), 16'(got.divider_code));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ENABLED;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    scan_scoreboard sb;
    bit             in_burst = 1'b0;
    bit             out_burst = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    adc_scan_with_channel_fifos u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_in_item mk_item(logic [1:0] func, logic [CHAN_W-1:0] chan,
                                         logic [SAMPLE_W-1:0] smp);
        t_in_item it;
        it.func    = func;
        it.channel = chan;
        it.sample  = smp;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.expected_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_answer(o_out_data);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        t_in_item            it;
        int                  r;
        logic [MASK_W-1:0]   mask;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: empty mask, prescale 7
        send_item(mk_item(FUNC_START, 4'd0, 12'h000));
        send_item(mk_item(FUNC_TIMEOUT, 4'd0, 12'h000));
        send_item(mk_item(FUNC_SAMPLE, 4'd15, 12'hFFF));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd0, 12'hFFF));
        send_item(mk_item(FUNC_READ, 4'd0, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd15, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd12, 12'h000));
        drain_results();
        write_reg(CFG_ENABLED, 12'hFFF);
        write_reg(CFG_PRESCALE, 12'd0);

        // full scan, restart while scanning, full ring mid-scan, abort
        send_item(mk_item(FUNC_START, 4'd9, 12'h000));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'hAAA));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h555));
        send_item(mk_item(FUNC_START, 4'd0, 12'h000));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h123));
        send_item(mk_item(FUNC_TIMEOUT, 4'd0, 12'h000));
        send_item(mk_item(FUNC_TIMEOUT, 4'd0, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd1, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd0, 12'h000));
        drain_results();
        write_reg(CFG_ENABLED, 12'h801);
        write_reg(CFG_PRESCALE, 12'd5);

        send_item(mk_item(FUNC_START, 4'd0, 12'h000));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h001));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h800));
        send_item(mk_item(FUNC_START, 4'd0, 12'h000));
        drain_results();
        // mask changed while a scan is running
        write_reg(CFG_ENABLED, 12'h400);
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h7FF));
        send_item(mk_item(FUNC_SAMPLE, 4'd0, 12'h3C3));
        send_item(mk_item(FUNC_READ, 4'd10, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd11, 12'h000));
        send_item(mk_item(FUNC_READ, 4'd0, 12'h000));

        for (int ph = 0; ph < 15; ph++) begin
            drain_results();
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if (ph == 0) begin
                write_reg(CFG_ENABLED, 12'hFFF);
                write_reg(CFG_PRESCALE, 12'd7);
            end else if (ph == 1) begin
                write_reg(CFG_ENABLED, 12'h000);
                write_reg(CFG_PRESCALE, 12'd0);
            end else begin
                r = $urandom_range(0, 5);
                if (r == 0) mask = '0;
                else if (r == 1) mask = '1;
                else if (r == 2) mask = MASK_W'(1) << $urandom_range(0, NUM_CHANNELS - 1);
                else mask = MASK_W'($urandom);
                write_reg(CFG_ENABLED, CFG_DATA_W'(mask));
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_PRESCALE, CFG_DATA_W'($urandom_range(0, 7)));
            end
            for (int n = 0; n < 50; n++) begin
                r = $urandom_range(0, 99);
                it.channel = CHAN_W'($urandom);
                it.sample  = SAMPLE_W'($urandom);
                if (r < 45) begin
                    it.func = FUNC_SAMPLE;
                    if ($urandom_range(0, 9) == 0)
                        it.sample = $urandom_range(0, 1) ? '1 : '0;
                end else if (r < 75) begin
                    it.func = FUNC_READ;
                    if ($urandom_range(0, 99) < 85)
                        it.channel = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
                end else if (r < 90) begin
                    it.func = FUNC_START;
                end else begin
                    it.func = FUNC_TIMEOUT;
                end
                send_item(it);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
